FILE: rtl/pmsbm_pkg.sv
package pmsbm_pkg;

  localparam int unsigned Pixels     = 524288;
  localparam int unsigned PixW       = $clog2(Pixels);
  localparam int unsigned MaxFrames  = 1024;
  localparam int unsigned FrameW     = $clog2(MaxFrames);
  localparam int unsigned CountW     = FrameW + 1;
  localparam int unsigned CountReset = 32;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned MeanW      = 16;
  localparam int unsigned SqW        = 2 * MeanW;
  localparam int unsigned SumW       = 42;
  localparam int unsigned RemW       = CountW;
  localparam int unsigned RootW      = SumW / 2;
  localparam int unsigned SremW      = RootW + 4;
  localparam int unsigned NumCh      = 3;

  localparam int unsigned MeanDivSteps = 2;
  localparam int unsigned MeanStages   = MeanW / MeanDivSteps;
  localparam int unsigned ADepth       = MeanStages + 2;
  localparam int unsigned SumDivSteps  = 3;
  localparam int unsigned SumDivStages = SumW / SumDivSteps;
  localparam int unsigned SqrtSteps    = 3;
  localparam int unsigned SqrtStages   = RootW / SqrtSteps;
  localparam int unsigned BDepth       = SumDivStages + SqrtStages;

  localparam logic CmdMean = 1'b0;
  localparam logic CmdDev  = 1'b1;

  typedef struct packed {
    logic              command;
    logic [FrameW-1:0] frame_index;
    logic [PixW-1:0]   pixel_index;
    logic [ChanW-1:0]  hue;
    logic [ChanW-1:0]  saturation;
    logic [ChanW-1:0]  brightness;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0]  out_pixel;
    logic [MeanW-1:0] hue_mean;
    logic [MeanW-1:0] sat_mean;
    logic [MeanW-1:0] val_mean;
    logic [MeanW-1:0] hue_std;
    logic [MeanW-1:0] sat_std;
    logic [MeanW-1:0] val_std;
  } out_item_t;

  typedef logic [NumCh-1:0][MeanW-1:0] mean_vec_t;
  typedef logic [NumCh-1:0][SumW-1:0]  sum_vec_t;

  typedef struct packed {
    logic                          valid;
    logic                          cmd;
    logic                          first;
    logic                          last;
    logic [PixW-1:0]               pix;
    logic [RemW-1:0]               dvs;
    logic [NumCh-1:0][ChanW-1:0]   x;
    mean_vec_t                     mean;
    logic [NumCh-1:0]              neg;
    logic [NumCh-1:0][RemW-1:0]    rem;
    sum_vec_t                      nq;
    logic [NumCh-1:0][SqW-1:0]     sq;
    sum_vec_t                      sum;
  } a_stage_t;

  typedef struct packed {
    logic                          valid;
    logic [PixW-1:0]               pix;
    mean_vec_t                     mean;
    logic [NumCh-1:0][RemW-1:0]    rem;
    sum_vec_t                      nq;
    logic [NumCh-1:0][RootW-1:0]   root;
    logic [NumCh-1:0][SremW-1:0]   srem;
  } b_stage_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [SumW-1:0] nq;
  } div_res_t;

  typedef struct packed {
    logic [SremW-1:0] srem;
    logic [RootW-1:0] root;
    logic [SumW-1:0]  nq;
  } sqrt_res_t;

  // one restoring division step, quotient bits shift into the low end
  function automatic div_res_t div_step(input logic [RemW-1:0] rem,
                                        input logic [SumW-1:0] nq,
                                        input logic [RemW-1:0] dvs);
    logic [RemW-1:0] r2;
    div_res_t        res;
    r2     = {rem[RemW-2:0], nq[SumW-1]};
    res.nq = {nq[SumW-2:0], 1'b0};
    if (r2 >= dvs) begin
      res.rem   = r2 - dvs;
      res.nq[0] = 1'b1;
    end else begin
      res.rem = r2;
    end
    return res;
  endfunction

  // one digit-by-digit root step, two radicand bits per step
  function automatic sqrt_res_t sqrt_step(input logic [SremW-1:0] srem,
                                          input logic [RootW-1:0] root,
                                          input logic [SumW-1:0]  nq);
    logic [SremW-1:0] t;
    logic [SremW-1:0] trial;
    sqrt_res_t        res;
    t      = {srem[SremW-3:0], nq[SumW-1:SumW-2]};
    trial  = {2'b00, root, 2'b01};
    res.nq = {nq[SumW-3:0], 2'b00};
    if (t >= trial) begin
      res.srem = t - trial;
      res.root = {root[RootW-2:0], 1'b1};
    end else begin
      res.srem = t;
      res.root = {root[RootW-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

FILE: rtl/pixel_mean_std_background_model.sv
// throughput: one item per cycle while the output is not stalled; an item
//   whose pixel is still in the first 10 stages (read-modify-write window
//   of the stores) waits until it leaves
// reset: asynchronous, clears valid bits and sets frame_count to 32;
//   the mean and square-sum stores are not cleared
module pixel_mean_std_background_model (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  pmsbm_pkg::in_item_t         in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output pmsbm_pkg::out_item_t        out_item_o,
  input  logic                        cfg_we_i,
  input  logic [pmsbm_pkg::CountW-1:0] cfg_data_i
);
  import pmsbm_pkg::*;

  logic [CountW-1:0] frame_count_q;
  logic [CountW-1:0] count;
  logic [RemW-1:0]   divisor;

  a_stage_t a_q [1:ADepth];
  a_stage_t a_d [1:ADepth];
  b_stage_t b_q [1:BDepth];
  b_stage_t b_d [1:BDepth];

  logic      adv;
  logic      hazard;
  logic      accept;
  logic      keep;
  mean_vec_t mean_rd;
  sum_vec_t  sum_rd;
  mean_vec_t mean_wr;
  logic      mean_we;
  logic      sum_we;

  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t out_item_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= CountW'(CountReset);
    end else if (cfg_we_i) begin
      frame_count_q <= cfg_data_i;
    end
  end

  always_comb begin
    count   = (frame_count_q > CountW'(MaxFrames)) ? CountW'(MaxFrames) : frame_count_q;
    divisor = (count > CountW'(1)) ? RemW'(count - CountW'(1)) : RemW'(1);
  end

  assign adv = !(b_q[BDepth].valid && out_valid_q && out_stall_i);

  always_comb begin
    hazard = 1'b0;
    for (int k = 1; k <= ADepth; k++) begin
      if (a_q[k].valid && (a_q[k].pix == in_item_i.pixel_index)) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_stall_o = !adv || hazard;
  assign accept     = in_valid_i && !in_stall_o;
  assign keep       = accept && (CountW'(in_item_i.frame_index) < count);

  pmsbm_ram #(
    .Width(NumCh * MeanW),
    .Depth(Pixels)
  ) u_mean_ram (
    .clk_i  (clk_i),
    .we_i   (mean_we),
    .waddr_i(a_q[ADepth].pix),
    .wdata_i(mean_wr),
    .re_i   (adv),
    .raddr_i(in_item_i.pixel_index),
    .rdata_o(mean_rd)
  );

  pmsbm_ram #(
    .Width(NumCh * SumW),
    .Depth(Pixels)
  ) u_sum_ram (
    .clk_i  (clk_i),
    .we_i   (sum_we),
    .waddr_i(a_q[ADepth].pix),
    .wdata_i(a_q[ADepth].sum),
    .re_i   (adv),
    .raddr_i(in_item_i.pixel_index),
    .rdata_o(sum_rd)
  );

  // read-modify-write stages: difference, mean division, square and sum
  always_comb begin
    logic [MeanW-1:0] xs;
    logic [MeanW-1:0] ad;
    div_res_t         r;
    for (int k = 1; k <= ADepth; k++) begin
      a_d[k] = '0;
    end
    a_d[1].valid = keep;
    a_d[1].cmd   = in_item_i.command;
    a_d[1].first = (in_item_i.frame_index == '0);
    a_d[1].last  = (CountW'(in_item_i.frame_index) == (count - CountW'(1)));
    a_d[1].pix   = in_item_i.pixel_index;
    a_d[1].dvs   = RemW'(in_item_i.frame_index) + RemW'(1);
    a_d[1].x[0]  = in_item_i.hue;
    a_d[1].x[1]  = in_item_i.saturation;
    a_d[1].x[2]  = in_item_i.brightness;

    a_d[2] = a_q[1];
    for (int c = 0; c < NumCh; c++) begin
      xs                = {a_q[1].x[c], (MeanW-ChanW)'(0)};
      a_d[2].mean[c]    = mean_rd[c];
      a_d[2].neg[c]     = mean_rd[c] > xs;
      ad                = a_d[2].neg[c] ? (mean_rd[c] - xs) : (xs - mean_rd[c]);
      a_d[2].rem[c]     = '0;
      a_d[2].nq[c]      = {ad, (SumW-MeanW)'(0)};
      a_d[2].sum[c]     = sum_rd[c];
    end

    for (int k = 3; k <= ADepth; k++) begin
      a_d[k] = a_q[k-1];
      for (int c = 0; c < NumCh; c++) begin
        if (k == 3) begin
          ad           = a_q[2].nq[c][SumW-1 -: MeanW];
          a_d[k].sq[c] = SqW'(ad) * SqW'(ad);
        end
        if (k == 4) begin
          a_d[k].sum[c] = a_q[3].first ? SumW'(a_q[3].sq[c])
                                       : a_q[3].sum[c] + SumW'(a_q[3].sq[c]);
        end
        for (int s = 0; s < MeanDivSteps; s++) begin
          r                = div_step(a_d[k].rem[c], a_d[k].nq[c], a_q[k-1].dvs);
          a_d[k].rem[c]    = r.rem;
          a_d[k].nq[c]     = r.nq;
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      mean_wr[c] = a_q[ADepth].neg[c]
                 ? a_q[ADepth].mean[c] - a_q[ADepth].nq[c][MeanW-1:0]
                 : a_q[ADepth].mean[c] + a_q[ADepth].nq[c][MeanW-1:0];
    end
  end

  assign mean_we = adv && a_q[ADepth].valid && (a_q[ADepth].cmd == CmdMean);
  assign sum_we  = adv && a_q[ADepth].valid && (a_q[ADepth].cmd == CmdDev);

  // result stages: sum over divisor, then the floored root
  always_comb begin
    b_stage_t  src;
    div_res_t  r;
    sqrt_res_t q;
    for (int k = 1; k <= BDepth; k++) begin
      if (k == 1) begin
        src       = '0;
        src.valid = a_q[ADepth].valid && (a_q[ADepth].cmd == CmdDev) && a_q[ADepth].last;
        src.pix   = a_q[ADepth].pix;
        src.mean  = a_q[ADepth].mean;
        src.nq    = a_q[ADepth].sum;
      end else begin
        src = b_q[k-1];
      end
      b_d[k] = src;
      for (int c = 0; c < NumCh; c++) begin
        if (k <= SumDivStages) begin
          for (int s = 0; s < SumDivSteps; s++) begin
            r              = div_step(b_d[k].rem[c], b_d[k].nq[c], divisor);
            b_d[k].rem[c]  = r.rem;
            b_d[k].nq[c]   = r.nq;
          end
        end else begin
          for (int s = 0; s < SqrtSteps; s++) begin
            q              = sqrt_step(b_d[k].srem[c], b_d[k].root[c], b_d[k].nq[c]);
            b_d[k].srem[c] = q.srem;
            b_d[k].root[c] = q.root;
            b_d[k].nq[c]   = q.nq;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= ADepth; k++) begin
        a_q[k].valid <= 1'b0;
      end
      for (int k = 1; k <= BDepth; k++) begin
        b_q[k].valid <= 1'b0;
      end
    end else if (adv) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  always_comb begin
    logic [NumCh-1:0][MeanW-1:0] sd;
    for (int c = 0; c < NumCh; c++) begin
      sd[c] = (b_q[BDepth].root[c] > RootW'({MeanW{1'b1}}))
            ? {MeanW{1'b1}} : b_q[BDepth].root[c][MeanW-1:0];
    end
    out_item_d.out_pixel = b_q[BDepth].pix;
    out_item_d.hue_mean  = b_q[BDepth].mean[0];
    out_item_d.sat_mean  = b_q[BDepth].mean[1];
    out_item_d.val_mean  = b_q[BDepth].mean[2];
    out_item_d.hue_std   = sd[0];
    out_item_d.sat_std   = sd[1];
    out_item_d.val_std   = sd[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= b_q[BDepth].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: rtl/pmsbm_ram.sv
module pmsbm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pmsbm_chk.sv
module pmsbm_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input pmsbm_pkg::in_item_t          in_item_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input pmsbm_pkg::out_item_t         out_item_o,
  input logic                         cfg_we_i,
  input logic [pmsbm_pkg::CountW-1:0] cfg_data_i
);
  import pmsbm_pkg::*;

  localparam int unsigned PendMax = ADepth + BDepth + 1;
  localparam int unsigned PendW   = $clog2(PendMax + 1) + 1;

  logic [CountW-1:0] cnt_q;
  logic [CountW-1:0] cnt;
  logic [PendW-1:0]  pend_q;
  logic [PendW-1:0]  pend_d;
  logic              last_acc;
  logic              out_hs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CountW'(CountReset);
    end else if (cfg_we_i) begin
      cnt_q <= cfg_data_i;
    end
  end

  assign cnt      = (cnt_q > CountW'(MaxFrames)) ? CountW'(MaxFrames) : cnt_q;
  assign last_acc = in_valid_i && !in_stall_o && (in_item_i.command == CmdDev)
                 && (CountW'(in_item_i.frame_index) < cnt)
                 && (CountW'(in_item_i.frame_index) == (cnt - CountW'(1)));
  assign out_hs   = out_valid_o && !out_stall_i;
  assign pend_d   = pend_q + PendW'(last_acc) - PendW'(out_hs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled item changed");

  a_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("item shown during reset");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("item with no matching last-frame input");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PendW'(PendMax))
    else $error("more items in flight than stages");

endmodule

bind pixel_mean_std_background_model pmsbm_chk u_pmsbm_chk (.*);
